// ===== src/dbt_pkg.sv =====
// Shared types and constants of the display blank timeout block.
// Used by the channel interfaces, the state core and the top level.
package dbt_pkg;

	localparam int unsigned OP_W       = 3;
	localparam int unsigned LIGHT_W    = 16;
	localparam int unsigned TIMEOUT_W  = 24;
	localparam int unsigned LEVEL_W    = 8;
	localparam int unsigned MODE_W     = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 24;

	// Event codes carried in the operation field.
	localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
	localparam logic [OP_W-1:0] OP_BLANK   = 3'd1;
	localparam logic [OP_W-1:0] OP_WAKE    = 3'd2;
	localparam logic [OP_W-1:0] OP_RESTART = 3'd3;
	localparam logic [OP_W-1:0] OP_TOUCH   = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKLIGHT = 2'd2;

	// Reset values.
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET   = 24'd30000;
	localparam logic [LIGHT_W-1:0]   THRESHOLD_RESET = 16'd300;
	localparam logic [LEVEL_W-1:0]   BACKLIGHT_RESET = 8'd128;
	localparam logic [LEVEL_W-1:0]   SAVER_LEVEL     = 8'd1;

	typedef struct packed {
		logic [TIMEOUT_W-1:0] timeout_ticks;
		logic [LIGHT_W-1:0]   light_limit;
		logic [LEVEL_W-1:0]   normal_backlight;
	} cfg_t;

	typedef struct packed {
		logic [MODE_W-1:0]  screen_mode;
		logic               blank;
		logic [LEVEL_W-1:0] backlight_level;
		logic               illum_led;
		logic               expired;
	} result_t;

endpackage

// ===== src/dbt_if.sv =====
// Valid/ready channel interfaces for event transactions and result transactions.
// Depends on dbt_pkg for field widths.
interface dbt_in_if import dbt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    operation;
	logic [LIGHT_W-1:0] ambient_light;

	modport source (output valid, output operation, output ambient_light, input ready);
	modport sink   (input valid, input operation, input ambient_light, output ready);
endinterface

interface dbt_out_if import dbt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  screen_mode;
	logic               blank;
	logic [LEVEL_W-1:0] backlight_level;
	logic               illum_led;
	logic               expired;

	modport source (output valid, output screen_mode, output blank, output backlight_level,
		output illum_led, output expired, input ready);
	modport sink   (input valid, input screen_mode, input blank, input backlight_level,
		input illum_led, input expired, output ready);
endinterface

// ===== src/dbt_core.sv =====
// Screen power state machine: mode, countdown and white LED state, plus the result register.
// Depends on dbt_pkg.
module dbt_core import dbt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_accept,
	input  logic [OP_W-1:0]    operation,
	input  logic [LIGHT_W-1:0] ambient_light,
	input  cfg_t               cfg,
	output result_t            result
);

	typedef enum logic [MODE_W-1:0] {
		MODE_ON       = 2'd0,
		MODE_COUNTING = 2'd1,
		MODE_BLANKED  = 2'd2,
		MODE_SAVER    = 2'd3
	} mode_t;

	mode_t                mode_q, mode_d;
	logic [TIMEOUT_W-1:0] countdown_q, countdown_d;
	logic                 led_q, led_d;
	logic                 fired;
	result_t              result_d, result_q;

	always_comb begin
		mode_d      = mode_q;
		countdown_d = countdown_q;
		led_d       = led_q;
		fired       = 1'b0;
		case (operation)
			OP_TICK: begin
				if (mode_q == MODE_COUNTING) begin
					if (countdown_q <= TIMEOUT_W'(1)) begin
						countdown_d = '0;
						led_d       = 1'b0;
						fired       = 1'b1;
						mode_d      = (ambient_light > cfg.light_limit) ?
							MODE_BLANKED : MODE_SAVER;
					end else begin
						countdown_d = countdown_q - TIMEOUT_W'(1);
					end
				end
			end
			OP_BLANK: begin
				if (mode_q == MODE_ON) begin
					countdown_d = cfg.timeout_ticks;
					mode_d      = MODE_COUNTING;
				end
			end
			OP_WAKE: begin
				mode_d = MODE_ON;
			end
			OP_RESTART: begin
				if (mode_q != MODE_ON) begin
					countdown_d = cfg.timeout_ticks;
					mode_d      = MODE_COUNTING;
				end
			end
			OP_TOUCH: begin
				if (mode_q != MODE_ON) begin
					countdown_d = cfg.timeout_ticks;
					mode_d      = MODE_COUNTING;
				end
				if (ambient_light < cfg.light_limit) begin
					led_d = 1'b1;
				end
			end
			default: begin
			end
		endcase

		result_d.screen_mode     = mode_d;
		result_d.blank           = (mode_d == MODE_BLANKED);
		result_d.backlight_level = (mode_d == MODE_SAVER) ? SAVER_LEVEL : cfg.normal_backlight;
		result_d.illum_led       = led_d;
		result_d.expired         = fired;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_COUNTING;
			countdown_q <= TIMEOUT_RESET;
			led_q       <= 1'b0;
			result_q    <= '0;
		end else if (item_accept) begin
			mode_q      <= mode_d;
			countdown_q <= countdown_d;
			led_q       <= led_d;
			result_q    <= result_d;
		end
	end

	assign result = result_q;

endmodule

// ===== src/display_blank_timeout_fsm.sv =====
// Top level of the screen power manager: configuration registers, channel handshake
// and the result register valid flag. Depends on dbt_pkg, dbt_if and dbt_core.

// The block manages screen power in four modes (on, counting down, blanked, saver) and
// takes one event transaction per cycle while the result channel does not stall: a
// millisecond tick, a blank request, a wake request, a wake-and-restart or a touch
// release, each with the current ambient light reading. Every event transaction produces
// exactly one result transaction that shows the mode after the event, the blank flag, the
// commanded backlight level, the white LED state and a one-shot expiry flag. The state
// update logic writes the new state and the result register at the accepting clock edge,
// so the result is offered in the cycle after acceptance and the sustained rate is one
// transaction per clock while results are taken. The result register is the only buffer;
// a new event is accepted whenever that register is empty or being emptied in the same
// cycle. Configuration writes (countdown length, light threshold, normal backlight) take
// effect at the next event and are meant to happen while no result is pending.
// After reset the block is counting down from 30000 ticks with the white LED off.
module display_blank_timeout_fsm import dbt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	dbt_in_if.sink                in_ch,
	dbt_out_if.source             out_ch
);

	cfg_t    cfg_q;
	result_t result;
	logic    out_valid_q;
	logic    item_accept;

	// Configuration registers; writes to an unused index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks    <= TIMEOUT_RESET;
			cfg_q.light_limit      <= THRESHOLD_RESET;
			cfg_q.normal_backlight <= BACKLIGHT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_TIMEOUT:   cfg_q.timeout_ticks    <= cfg_data[TIMEOUT_W-1:0];
				CFG_THRESHOLD: cfg_q.light_limit      <= cfg_data[LIGHT_W-1:0];
				CFG_BACKLIGHT: cfg_q.normal_backlight <= cfg_data[LEVEL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// A new transaction may enter when the result register is free or drains this cycle.
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign item_accept = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	dbt_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_accept   (item_accept),
		.operation     (in_ch.operation),
		.ambient_light (in_ch.ambient_light),
		.cfg           (cfg_q),
		.result        (result)
	);

	assign out_ch.valid           = out_valid_q;
	assign out_ch.screen_mode     = result.screen_mode;
	assign out_ch.blank           = result.blank;
	assign out_ch.backlight_level = result.backlight_level;
	assign out_ch.illum_led       = result.illum_led;
	assign out_ch.expired         = result.expired;

endmodule
